// ===== src/gbn_pkg.sv =====
// shared types, constants and slot arithmetic for the go-back-n sender window
package gbn_pkg;

    localparam int SEQ_COUNT = 20;
    localparam int SLOT_W    = 5;
    localparam int CNT_W     = 16;
    localparam int IDLE_W    = 8;
    localparam int CFG_IDX_W = 2;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_SIZE   = 2'd0,
        CFG_TOTAL_PACKETS = 2'd1,
        CFG_TIMEOUT_LIMIT = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [4:0]        window_size;
        cnt_t              total_packets;
        logic [IDLE_W-1:0] timeout_limit;
    } gbn_cfg_t;

    typedef struct packed {
        slot_t                next_slot;
        slot_t                base_slot;
        cnt_t                 sent_count;
        cnt_t                 acked_count;
        logic [IDLE_W-1:0]    idle_polls;
        logic [SEQ_COUNT-1:0] slot_free;
    } gbn_state_t;

    typedef struct packed {
        logic  send_valid;
        slot_t send_seq;
        cnt_t  packet_index;
        logic  timed_out;
        cnt_t  acked_total;
        logic  done_res;
    } gbn_res_t;

    localparam gbn_cfg_t CFG_RESET = '{
        window_size:   5'd10,
        total_packets: 16'd33,
        timeout_limit: 8'd20
    };

    localparam gbn_state_t STATE_CLEAR = '{
        next_slot:   '0,
        base_slot:   '0,
        sent_count:  '0,
        acked_count: '0,
        idle_polls:  '0,
        slot_free:   '1
    };

    // distance from b forward to a around the sequence ring
    function automatic slot_t slot_dist(input slot_t a, input slot_t b);
        logic [SLOT_W:0] wide;
        begin
            if (a >= b)
                wide = {1'b0, a} - {1'b0, b};
            else
                wide = {1'b0, a} + (SLOT_W+1)'(SEQ_COUNT) - {1'b0, b};
            return wide[SLOT_W-1:0];
        end
    endfunction

    // next slot around the ring
    function automatic slot_t slot_inc(input slot_t a);
        begin
            if (a == SLOT_W'(SEQ_COUNT - 1))
                return '0;
            else
                return a + SLOT_W'(1);
        end
    endfunction

endpackage

// ===== src/go_back_n_sender_window_unit.sv =====
// top level of the go-back-n sender window unit
//
//  channel  direction  handshake               payload
//  cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//  in       in         in_valid  / in_ready    start_req, ack_valid, ack_byte
//  out      out        out_valid / out_ready   send_valid, send_seq, packet_index,
//                                              timed_out, acked_total, done_res
//
// one poll per cycle while in_ready is high: a poll transaction updates the window
// state in the same cycle and its result appears on the out ports in the next
// cycle, from the result register
// in_ready drops only while a result is held and out_ready is low
// reset clears the window state and loads the default configuration
// cfg_ready is always high; the user must write config only while no poll is in flight, the block does not enforce it
module go_back_n_sender_window_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gbn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gbn_pkg::CNT_W-1:0]     cfg_data,
    // poll channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          start_req,
    input  logic                          ack_valid,
    input  logic [7:0]                    ack_byte,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          send_valid,
    output logic [gbn_pkg::SLOT_W-1:0]    send_seq,
    output logic [gbn_pkg::CNT_W-1:0]     packet_index,
    output logic                          timed_out,
    output logic [gbn_pkg::CNT_W-1:0]     acked_total,
    output logic                          done_res
);
    import gbn_pkg::*;

    gbn_cfg_t   cfg;
    gbn_state_t state_reg;
    gbn_state_t state_next;
    gbn_state_t state_step;
    gbn_res_t   res_step;
    gbn_res_t   res_out;
    logic       poll_take;

    // configuration registers
    gbn_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // poll logic works straight off the window state and the poll inputs
    gbn_poll_step u_step (
        .cfg       (cfg),
        .state_cur (state_reg),
        .start_req (start_req),
        .ack_valid (ack_valid),
        .ack_byte  (ack_byte),
        .state_new (state_step),
        .res       (res_step)
    );

    // window state advances only on an accepted poll transaction
    assign poll_take  = in_valid && in_ready;
    assign state_next = poll_take ? state_step : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_CLEAR;
        else
            state_reg <= state_next;
    end

    // result register decouples the consumer from the poll side
    gbn_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .res_in    (res_step),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (res_out)
    );

    assign send_valid   = res_out.send_valid;
    assign send_seq     = res_out.send_seq;
    assign packet_index = res_out.packet_index;
    assign timed_out    = res_out.timed_out;
    assign acked_total  = res_out.acked_total;
    assign done_res     = res_out.done_res;

endmodule

// ===== src/gbn_cfg_regs.sv =====
// configuration registers of the go-back-n sender window
module gbn_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gbn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gbn_pkg::CNT_W-1:0]     cfg_data,
    output gbn_pkg::gbn_cfg_t             cfg
);
    import gbn_pkg::*;

    gbn_cfg_t cfg_reg;
    gbn_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_WINDOW_SIZE:   cfg_next.window_size   = cfg_data[4:0];
                CFG_TOTAL_PACKETS: cfg_next.total_packets = cfg_data;
                CFG_TIMEOUT_LIMIT: cfg_next.timeout_limit = cfg_data[IDLE_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

endmodule

// ===== src/gbn_poll_step.sv =====
// one poll of the sender window: optional restart, send, then ack or idle count and rewind
module gbn_poll_step (
    input  gbn_pkg::gbn_cfg_t   cfg,
    input  gbn_pkg::gbn_state_t state_cur,
    input  logic                start_req,
    input  logic                ack_valid,
    input  logic [7:0]          ack_byte,
    output gbn_pkg::gbn_state_t state_new,
    output gbn_pkg::gbn_res_t   res
);
    import gbn_pkg::*;

    gbn_state_t      s;
    slot_t           outst0;
    slot_t           outst1;
    slot_t           eff_win;
    logic            send;
    logic [7:0]      idx8;
    logic            idx_ok;
    slot_t           idx;
    slot_t           d;
    logic            ack_hit;
    logic [IDLE_W:0] idle_inc;
    logic            rewind;
    slot_t           dist_j;

    always_comb
    begin
        s = state_cur;
        if (start_req)
            s = STATE_CLEAR;

        // clamp window to keep it below the sequence count
        eff_win = (cfg.window_size > SLOT_W'(SEQ_COUNT - 1)) ?
                  SLOT_W'(SEQ_COUNT - 1) : cfg.window_size;

        outst0 = slot_dist(s.next_slot, s.base_slot);
        send   = (outst0 < eff_win) && s.slot_free[s.next_slot] &&
                 (s.sent_count < cfg.total_packets);

        res.send_valid   = send;
        res.send_seq     = send ? s.next_slot + SLOT_W'(1) : '0;
        res.packet_index = send ? s.sent_count : '0;

        if (send)
        begin
            s.slot_free[s.next_slot] = 1'b0;
            s.next_slot              = slot_inc(s.next_slot);
            s.sent_count             = s.sent_count + CNT_W'(1);
        end

        outst1   = slot_dist(s.next_slot, s.base_slot);
        idx8     = ack_byte - 8'd1;
        idx_ok   = idx8 < 8'(SEQ_COUNT);
        idx      = idx8[SLOT_W-1:0];
        d        = slot_dist(idx, s.base_slot);
        ack_hit  = ack_valid && idx_ok && (d < outst1);
        idle_inc = {1'b0, s.idle_polls} + (IDLE_W+1)'(1);
        rewind   = !ack_valid && (idle_inc > {1'b0, cfg.timeout_limit});

        // free slots ahead of base: acked span on an ack, window on a rewind
        for (int j = 0; j < SEQ_COUNT; j++)
        begin
            dist_j = slot_dist(SLOT_W'(j), s.base_slot);
            if ((ack_hit && (dist_j <= d)) || (rewind && (dist_j < eff_win)))
                s.slot_free[SLOT_W'(j)] = 1'b1;
        end

        if (ack_valid)
        begin
            s.idle_polls = '0;
            if (ack_hit)
            begin
                s.acked_count = s.acked_count + CNT_W'(d) + CNT_W'(1);
                s.base_slot   = slot_inc(idx);
            end
        end
        else if (rewind)
        begin
            s.idle_polls = '0;
            s.sent_count = s.sent_count - CNT_W'(outst1);
            s.next_slot  = s.base_slot;
        end
        else
        begin
            s.idle_polls = idle_inc[IDLE_W-1:0];
        end

        res.timed_out   = rewind;
        res.acked_total = s.acked_count;
        res.done_res    = (s.acked_count == cfg.total_packets);
        state_new       = s;
    end

endmodule

// ===== src/gbn_out_stage.sv =====
// result register with valid/ready handshake toward the consumer
module gbn_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  gbn_pkg::gbn_res_t res_in,
    output logic              out_valid,
    input  logic              out_ready,
    output gbn_pkg::gbn_res_t res_out
);
    import gbn_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    gbn_res_t res_reg;
    logic     load;

    assign in_ready   = !valid_reg || out_ready;
    assign load       = in_valid && in_ready;
    assign valid_next = load || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign res_out    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_in;
    end

endmodule
